// ===== hdl/u8wc_pkg.sv =====
// Shared types and constants for the UTF-8 wide character tracker.
// Used by every module of the block but u8wc_ram; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8wc_pkg;

  // Item kinds
  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_DIRTY = 1'b1;

  // Seen bitmap: 65536 bits kept as 2048 rows of 32 bits
  localparam int unsigned MAP_ROW_W  = 32;
  localparam int unsigned MAP_ROWS   = 2048;
  localparam int unsigned ROW_AW     = $clog2(MAP_ROWS);
  localparam int unsigned BIT_AW     = $clog2(MAP_ROW_W);

  // Decoder widths
  localparam int unsigned PART_W     = 15;  // widest pending partial (4-byte lead + 2 cont)
  localparam int unsigned CP_W       = 16;
  localparam int unsigned FULL_W     = PART_W + 6;

  // Output queue
  localparam int unsigned OQ_DEPTH   = 3;
  localparam int unsigned OQ_PW      = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW      = $clog2(OQ_DEPTH + 1);

  // Wide script ranges
  localparam logic [CP_W-1:0] CJK_LO    = 16'h2E80;
  localparam logic [CP_W-1:0] CJK_HI    = 16'h9FFF;
  localparam logic [CP_W-1:0] HANGUL_LO = 16'hAC00;
  localparam logic [CP_W-1:0] HANGUL_HI = 16'hD7AF;
  localparam logic [CP_W-1:0] COMPAT_LO = 16'hF900;
  localparam logic [CP_W-1:0] COMPAT_HI = 16'hFAFF;
  localparam logic [CP_W-1:0] FULLW_LO  = 16'hFF00;
  localparam logic [CP_W-1:0] FULLW_HI  = 16'hFFEF;

  // Decoded item, registered alongside the bitmap read
  typedef struct packed {
    logic            valid;
    logic            kind;
    logic            lookup;   // completed wide code point, check bitmap
    logic [CP_W-1:0] cp;
  } dec_t;

  // One result
  typedef struct packed {
    logic            newly_seen;
    logic [CP_W-1:0] code_point;
    logic            dirty_out;
  } res_t;

  function automatic logic is_wide(input logic [CP_W-1:0] cp);
    is_wide = (cp >= CJK_LO    && cp <= CJK_HI)    ||
              (cp >= HANGUL_LO && cp <= HANGUL_HI) ||
              (cp >= COMPAT_LO && cp <= COMPAT_HI) ||
              (cp >= FULLW_LO  && cp <= FULLW_HI);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/u8wc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module u8wc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8wc_decode.sv =====
// UTF-8 byte decoder: sequence state, code point assembly, wide range check.
// Depends on u8wc_pkg. Issues the bitmap row address in the accept cycle.
`timescale 1ns / 1ps
`default_nettype none

module u8wc_decode (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic                       kind_i,
  input  wire logic [7:0]                 text_byte_i,
  input  wire logic                       end_of_text_i,
  output logic [u8wc_pkg::ROW_AW-1:0]     rd_addr_o,
  output u8wc_pkg::dec_t                  dec_o
);

  logic [u8wc_pkg::PART_W-1:0] partial_q, partial_d;
  logic [1:0]                  left_q, left_d;
  logic [u8wc_pkg::FULL_W-1:0] full_cp;
  logic                        cont;
  logic                        complete;
  logic                        lookup;
  u8wc_pkg::dec_t              dec_q;

  assign full_cp   = {partial_q, text_byte_i[5:0]};
  assign cont      = (left_q != 2'd0) && (text_byte_i[7:6] == 2'b10);
  assign rd_addr_o = full_cp[u8wc_pkg::CP_W-1:u8wc_pkg::BIT_AW];

  always_comb begin
    partial_d = partial_q;
    left_d    = left_q;
    complete  = 1'b0;
    if (kind_i == u8wc_pkg::KIND_TEXT) begin
      if (cont) begin
        left_d = left_q - 2'd1;
        if (left_q == 2'd1) begin
          complete  = 1'b1;
          partial_d = '0;
        end else begin
          partial_d = full_cp[u8wc_pkg::PART_W-1:0];
        end
      end else begin
        // broken sequence or fresh lead
        partial_d = '0;
        left_d    = 2'd0;
        if (text_byte_i >= 8'hF0) begin
          left_d    = 2'd3;
          partial_d = u8wc_pkg::PART_W'(text_byte_i[2:0]);
        end else if (text_byte_i >= 8'hE0) begin
          left_d    = 2'd2;
          partial_d = u8wc_pkg::PART_W'(text_byte_i[3:0]);
        end else if (text_byte_i >= 8'hC0) begin
          left_d    = 2'd1;
          partial_d = u8wc_pkg::PART_W'(text_byte_i[4:0]);
        end
      end
      if (end_of_text_i) begin
        partial_d = '0;
        left_d    = 2'd0;
      end
    end
  end

  assign lookup = complete
               && (full_cp[u8wc_pkg::FULL_W-1:u8wc_pkg::CP_W] == '0)
               && u8wc_pkg::is_wide(full_cp[u8wc_pkg::CP_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      left_q    <= 2'd0;
      dec_q     <= '0;
    end else begin
      dec_q.valid <= accept_i;
      if (accept_i) begin
        partial_q    <= partial_d;
        left_q       <= left_d;
        dec_q.kind   <= kind_i;
        dec_q.lookup <= lookup;
        dec_q.cp     <= full_cp[u8wc_pkg::CP_W-1:0];
      end
    end
  end

  assign dec_o = dec_q;

`ifndef SYNTHESIS
  // Partial bits are empty whenever no sequence is pending
  a_partial_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q == 2'd0) |-> (partial_q == '0))
    else $error("partial point held with no sequence pending");
`endif

endmodule

`default_nettype wire

// ===== hdl/u8wc_seen.sv =====
// Seen bitmap: clearing sweep after reset, row read-modify-write with
// forwarding of the last write, and the dirty flag. Depends on u8wc_pkg, u8wc_ram.
`timescale 1ns / 1ps
`default_nettype none

module u8wc_seen (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       rd_en_i,
  input  wire logic [u8wc_pkg::ROW_AW-1:0] rd_addr_i,
  input  wire u8wc_pkg::dec_t             dec_i,
  output logic                            clear_busy_o,
  output logic                            res_valid_o,
  output u8wc_pkg::res_t                  res_o
);

  logic [u8wc_pkg::ROW_AW-1:0]    clr_cnt_q;
  logic                           clr_busy_q;
  logic                           dirty_q, dirty_d;

  logic                           fwd_valid_q;
  logic [u8wc_pkg::ROW_AW-1:0]    fwd_addr_q;
  logic [u8wc_pkg::MAP_ROW_W-1:0] fwd_data_q;

  logic [u8wc_pkg::MAP_ROW_W-1:0] rd_data;
  logic [u8wc_pkg::MAP_ROW_W-1:0] row;
  logic [u8wc_pkg::MAP_ROW_W-1:0] row_new;
  logic [u8wc_pkg::ROW_AW-1:0]    item_row;
  logic [u8wc_pkg::BIT_AW-1:0]    item_bit;
  logic                           fresh;

  logic                           we;
  logic [u8wc_pkg::ROW_AW-1:0]    waddr;
  logic [u8wc_pkg::MAP_ROW_W-1:0] wdata;

  assign item_row = dec_i.cp[u8wc_pkg::CP_W-1:u8wc_pkg::BIT_AW];
  assign item_bit = dec_i.cp[u8wc_pkg::BIT_AW-1:0];

  // the previous item's write lands at the edge this item's read was taken
  assign row     = (fwd_valid_q && fwd_addr_q == item_row) ? fwd_data_q : rd_data;
  assign fresh   = dec_i.valid && (dec_i.kind == u8wc_pkg::KIND_TEXT)
                && dec_i.lookup && !row[item_bit];
  assign row_new = row | (u8wc_pkg::MAP_ROW_W'(1) << item_bit);

  always_comb begin
    if (clr_busy_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else begin
      we    = fresh;
      waddr = item_row;
      wdata = row_new;
    end
  end

  u8wc_ram #(
    .WIDTH (u8wc_pkg::MAP_ROW_W),
    .DEPTH (u8wc_pkg::MAP_ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  always_comb begin
    dirty_d = dirty_q;
    res_o.newly_seen = fresh;
    res_o.code_point = fresh ? dec_i.cp : '0;
    res_o.dirty_out  = dirty_q;
    if (dec_i.valid) begin
      if (dec_i.kind == u8wc_pkg::KIND_DIRTY) begin
        dirty_d = 1'b0;
      end else if (fresh) begin
        dirty_d         = 1'b1;
        res_o.dirty_out = 1'b1;
      end
    end
  end

  assign res_valid_o  = dec_i.valid;
  assign clear_busy_o = clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      clr_busy_q  <= 1'b1;
      dirty_q     <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      dirty_q <= dirty_d;
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == u8wc_pkg::ROW_AW'(u8wc_pkg::MAP_ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (fresh) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fresh) begin
      fwd_addr_q <= item_row;
      fwd_data_q <= row_new;
    end
  end

`ifndef SYNTHESIS
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !dec_i.valid)
    else $error("item reached bitmap during clearing sweep");

  a_fresh_sets_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh |=> dirty_q)
    else $error("first sighting did not set dirty flag");
`endif

endmodule

`default_nettype wire

// ===== hdl/u8wc_out_fifo.sv =====
// Three-entry result queue between the bitmap stage and the output port.
// Depends on u8wc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8wc_out_fifo (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire u8wc_pkg::res_t           data_i,
  input  wire logic                     pop_i,
  output logic                          valid_o,
  output u8wc_pkg::res_t                data_o
);

  u8wc_pkg::res_t              entry_q [u8wc_pkg::OQ_DEPTH];
  logic [u8wc_pkg::OQ_PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [u8wc_pkg::OQ_CW-1:0]  count_q;
  logic                        do_pop;

  function automatic logic [u8wc_pkg::OQ_PW-1:0] ptr_next(
    input logic [u8wc_pkg::OQ_PW-1:0] p
  );
    ptr_next = (p == u8wc_pkg::OQ_PW'(u8wc_pkg::OQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != u8wc_pkg::OQ_CW'(u8wc_pkg::OQ_DEPTH) || do_pop))
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

// ===== hdl/utf8_wide_char_tracker.sv =====
// UTF-8 decoder with wide-script seen bitmap. Steps: decode + bitmap row read,
// then row update into the result queue. Throughput: one item per cycle unless
// the clearing sweep or a full queue stalls input; a bitmap row read-modify-write
// per item, with the last write forwarded. After reset the 2048-row bitmap is
// cleared one row a cycle while input stalls. Reset is asynchronous, active low.
// Depends on u8wc_pkg, u8wc_decode, u8wc_seen, u8wc_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

module utf8_wide_char_tracker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             newly_seen_o,
  output logic [15:0]      code_point_o,
  output logic             dirty_out_o
);

  logic                          accept;
  logic                          pop;
  logic                          clear_busy;
  logic [u8wc_pkg::ROW_AW-1:0]   rd_addr;
  u8wc_pkg::dec_t                dec;
  logic                          res_valid;
  u8wc_pkg::res_t                res;
  u8wc_pkg::res_t                head;
  logic [u8wc_pkg::OQ_CW-1:0]    occ_q;

  // items in flight: bitmap stage plus queue; never exceeds queue depth
  assign in_stall_o = clear_busy || (occ_q == u8wc_pkg::OQ_CW'(u8wc_pkg::OQ_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (accept && !pop) begin
      occ_q <= occ_q + 1'b1;
    end else if (!accept && pop) begin
      occ_q <= occ_q - 1'b1;
    end
  end

  u8wc_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .rd_addr_o     (rd_addr),
    .dec_o         (dec)
  );

  u8wc_seen u_seen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (rd_addr),
    .dec_i        (dec),
    .clear_busy_o (clear_busy),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  u8wc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign newly_seen_o = head.newly_seen;
  assign code_point_o = head.code_point;
  assign dirty_out_o  = head.dirty_out;

`ifndef SYNTHESIS
  a_out_needs_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != '0))
    else $error("result shown with nothing in flight");

  a_clear_ends_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clear_busy) |-> (occ_q == '0 && !out_valid_o))
    else $error("items in flight at end of clearing sweep");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_utf8_wide_char_tracker.sv =====
// Self-checking testbench for utf8_wide_char_tracker: directed UTF-8 cases, then random text.
// Predicts every result from its own decoder and seen bitmap, with random gaps and stalls.
// Depends on u8wc_pkg and utf8_wide_char_tracker.
`timescale 1ns / 1ps

module tb_utf8_wide_char_tracker;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = u8wc_pkg::KIND_TEXT;
  logic [7:0]  text_byte_i = 8'h00;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        newly_seen_o;
  logic [15:0] code_point_o;
  logic        dirty_out_o;

  utf8_wide_char_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .newly_seen_o  (newly_seen_o),
    .code_point_o  (code_point_o),
    .dirty_out_o   (dirty_out_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decoder and bitmap mirror
  logic [20:0]  utf8_acc = '0;
  logic [1:0]   utf8_cont_left = '0;
  bit           glyph_seen [0:65535];
  logic         font_dirty = 1'b0;

  u8wc_pkg::res_t due_results [$];
  int unsigned  recent_wide [$];
  int unsigned  items_sent = 0;
  int unsigned  err_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  cycle_count = 0;
  logic [7:0]   stall_phase = '0;

  function automatic logic in_wide_script(input logic [20:0] cp);
    in_wide_script = (cp >= u8wc_pkg::CJK_LO    && cp <= u8wc_pkg::CJK_HI)    ||
                     (cp >= u8wc_pkg::HANGUL_LO && cp <= u8wc_pkg::HANGUL_HI) ||
                     (cp >= u8wc_pkg::COMPAT_LO && cp <= u8wc_pkg::COMPAT_HI) ||
                     (cp >= u8wc_pkg::FULLW_LO  && cp <= u8wc_pkg::FULLW_HI);
  endfunction

  function automatic u8wc_pkg::res_t track_byte(input logic k, input logic [7:0] b,
                                                input logic eot);
    u8wc_pkg::res_t r;
    r = '0;
    if (k == u8wc_pkg::KIND_DIRTY) begin
      r.dirty_out = font_dirty;
      font_dirty  = 1'b0;
      return r;
    end
    if (utf8_cont_left != 2'd0 && b[7:6] == 2'b10) begin
      utf8_acc       = {utf8_acc[14:0], b[5:0]};
      utf8_cont_left = utf8_cont_left - 2'd1;
      if (utf8_cont_left == 2'd0) begin
        if (utf8_acc <= 21'h00FFFF && in_wide_script(utf8_acc) &&
            !glyph_seen[utf8_acc[15:0]]) begin
          glyph_seen[utf8_acc[15:0]] = 1'b1;
          font_dirty   = 1'b1;
          r.newly_seen = 1'b1;
          r.code_point = utf8_acc[15:0];
        end
        utf8_acc = '0;
      end
    end else begin
      // anything but a continuation abandons the pending sequence and acts as a lead
      utf8_cont_left = 2'd0;
      utf8_acc       = '0;
      if (b >= LEAD4_MIN) begin
        utf8_cont_left = 2'd3;
        utf8_acc       = {18'd0, b[2:0]};
      end else if (b >= LEAD3_MIN) begin
        utf8_cont_left = 2'd2;
        utf8_acc       = {17'd0, b[3:0]};
      end else if (b >= LEAD2_MIN) begin
        utf8_cont_left = 2'd1;
        utf8_acc       = {16'd0, b[4:0]};
      end
    end
    if (eot) begin
      utf8_cont_left = 2'd0;
      utf8_acc       = '0;
    end
    r.dirty_out = font_dirty;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Sender works in bursts; the gap before a burst may be empty.
  task automatic send_item(input logic k, input logic [7:0] b, input logic e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    text_byte_i   <= b;
    end_of_text_i <= e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due_results.push_back(track_byte(k, b, e));
    items_sent++;
  endtask

  // Encodes cp in n bytes, overlong when n exceeds the shortest form.
  task automatic send_utf8(input int unsigned cp, input int unsigned n, input logic eot_last);
    logic [20:0] v;
    logic [7:0]  lead;
    int          i;
    v = cp[20:0];
    if (n == 1) begin
      send_item(u8wc_pkg::KIND_TEXT, {1'b0, v[6:0]}, eot_last);
    end else begin
      case (n)
        2:       lead = {3'b110, v[10:6]};
        3:       lead = {4'b1110, v[15:12]};
        default: lead = {4'b1111, 1'($urandom_range(0, 1)), v[20:18]};
      endcase
      send_item(u8wc_pkg::KIND_TEXT, lead, 1'b0);
      for (i = n - 2; i >= 0; i--)
        send_item(u8wc_pkg::KIND_TEXT, {2'b10, v[6*i +: 6]}, eot_last && i == 0);
    end
  endtask

  function automatic int unsigned pick_code_point();
    int unsigned r, cp, lo, hi;
    r = $urandom_range(0, 99);
    if (r < 30 && recent_wide.size() != 0)
      return recent_wide[$urandom_range(0, recent_wide.size() - 1)];
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       begin lo = u8wc_pkg::CJK_LO;    hi = u8wc_pkg::CJK_HI;    end
        1:       begin lo = u8wc_pkg::HANGUL_LO; hi = u8wc_pkg::HANGUL_HI; end
        2:       begin lo = u8wc_pkg::COMPAT_LO; hi = u8wc_pkg::COMPAT_HI; end
        default: begin lo = u8wc_pkg::FULLW_LO;  hi = u8wc_pkg::FULLW_HI;  end
      endcase
      case ($urandom_range(0, 9))
        0:       cp = lo;
        1:       cp = hi;
        default: cp = $urandom_range(lo, hi);
      endcase
      recent_wide.push_back(cp);
      if (recent_wide.size() > 16) void'(recent_wide.pop_front());
      return cp;
    end
    case ($urandom_range(0, 5))
      0:       cp = $urandom_range(0, 'h7F);
      1:       cp = $urandom_range('h80, 'h7FF);
      2:       cp = $urandom_range('h800, u8wc_pkg::CJK_LO - 1);
      3:       cp = $urandom_range(u8wc_pkg::HANGUL_HI + 1, u8wc_pkg::COMPAT_LO - 1);
      4:       cp = $urandom_range(u8wc_pkg::COMPAT_HI + 1, 'hFFFF);
      default: cp = $urandom_range('h10000, 'h1FFFFF);
    endcase
    return cp;
  endfunction

  task automatic test_ignored_bytes();
    send_item(u8wc_pkg::KIND_TEXT, 8'hBF, 1'b0);  // stray continuation
    send_item(u8wc_pkg::KIND_TEXT, 8'hE4, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'h00, 1'b0);  // NUL drops the pending lead
  endtask

  task automatic test_first_sighting();
    send_utf8(u8wc_pkg::CJK_LO, 3, 1'b0);
    send_utf8(u8wc_pkg::CJK_LO, 3, 1'b1);         // repeat, end of text on the final byte
    send_item(u8wc_pkg::KIND_DIRTY, 8'h00, 1'b0);
  endtask

  task automatic test_broken_sequences();
    send_item(u8wc_pkg::KIND_TEXT, 8'hE4, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'hC3, 1'b0);  // new lead abandons the 3-byte sequence
    send_item(u8wc_pkg::KIND_TEXT, 8'hA9, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'hE4, 1'b1);  // end of text drops it right away
    send_item(u8wc_pkg::KIND_TEXT, 8'hB8, 1'b0);
  endtask

  task automatic test_long_forms();
    send_utf8(32'h2F00, 4, 1'b0);                 // overlong 4-byte form of a wide char
    send_item(u8wc_pkg::KIND_TEXT, 8'hFF, 1'b0);  // top lead: completes above 0xFFFF
    send_item(u8wc_pkg::KIND_TEXT, 8'hBF, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'hBF, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'hBF, 1'b0);
  endtask

  task automatic test_dirty_mid_sequence();
    send_item(u8wc_pkg::KIND_TEXT, 8'hEF, 1'b0);
    send_item(u8wc_pkg::KIND_DIRTY, 8'hFF, 1'b1); // payload is noise, decode state must hold
    send_item(u8wc_pkg::KIND_TEXT, 8'hBF, 1'b0);
    send_item(u8wc_pkg::KIND_TEXT, 8'hAF, 1'b0);
    send_item(u8wc_pkg::KIND_DIRTY, 8'h80, 1'b0);
  endtask

  task automatic test_random_text();
    int unsigned start, pick, cp, minb, nb, need, cut;
    logic [7:0]  lead;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        cp   = pick_code_point();
        minb = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        nb   = ($urandom_range(0, 5) == 0) ? $urandom_range(minb, 4) : minb;
        send_utf8(cp, nb, $urandom_range(0, 9) == 0);
      end else if (pick < 70) begin
        send_item(u8wc_pkg::KIND_DIRTY, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_item(u8wc_pkg::KIND_TEXT, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 15) == 0);
      end else begin
        // truncated sequence, then a byte that is not a continuation
        lead = 8'($urandom_range(LEAD2_MIN, 8'hFF));
        need = (lead >= LEAD4_MIN) ? 3 : (lead >= LEAD3_MIN) ? 2 : 1;
        cut  = $urandom_range(0, need - 1);
        send_item(u8wc_pkg::KIND_TEXT, lead, 1'b0);
        repeat (cut) send_item(u8wc_pkg::KIND_TEXT, 8'($urandom_range(8'h80, 8'hBF)), 1'b0);
        if ($urandom_range(0, 1))
          send_item(u8wc_pkg::KIND_TEXT, 8'($urandom_range(0, 8'h7F)),
                    $urandom_range(0, 3) == 0);
        else
          send_item(u8wc_pkg::KIND_TEXT, 8'($urandom_range(LEAD2_MIN, 8'hFF)),
                    $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Receiver stall pattern: free, light random, periodic, heavy random.
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 2) == 0);
      2'd2:    out_stall_i <= (stall_phase[2:0] < 3'd3);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    u8wc_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        report_mismatch("transfer with no result due", code_point_o, 0);
      end else begin
        want = due_results.pop_front();
        if (newly_seen_o !== want.newly_seen)
          report_mismatch("newly_seen", newly_seen_o, want.newly_seen);
        if (code_point_o !== want.code_point)
          report_mismatch("code_point", code_point_o, want.code_point);
        if (dirty_out_o !== want.dirty_out)
          report_mismatch("dirty_out", dirty_out_o, want.dirty_out);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_utf8_wide_char_tracker: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_bytes();
    test_first_sighting();
    test_broken_sequences();
    test_long_forms();
    test_dirty_mid_sequence();
    test_random_text();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0)
      $display("tb_utf8_wide_char_tracker: PASS");
    else
      $display("tb_utf8_wide_char_tracker: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/u8wc_pkg.sv
hdl/u8wc_ram.sv
hdl/u8wc_decode.sv
hdl/u8wc_seen.sv
hdl/u8wc_out_fifo.sv
hdl/utf8_wide_char_tracker.sv
dv/tb_utf8_wide_char_tracker.sv
